>>> hdl/morse_character_keyer_assert.svh
// assertion macros for the morse character keyer
// clocked on the rising edge, disabled while synchronous reset is low
`ifndef MORSE_CHARACTER_KEYER_ASSERT_SVH
`define MORSE_CHARACTER_KEYER_ASSERT_SVH

// same-cycle implication
`define MCK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mck_pkg.sv
// shared types, constants and the letter code table for the morse keyer
// no dependencies
package mck_pkg;

  localparam int unsigned DotW  = 16;
  localparam int unsigned DashW = 4;
  localparam int unsigned DurW  = 20;

  localparam logic [DotW-1:0]  DOT_TICKS_RESET  = 16'd250;
  localparam logic [DashW-1:0] DASH_UNITS_RESET = 4'd4;

  // configuration register indexes
  localparam logic CFG_DOT_TICKS  = 1'b0;
  localparam logic CFG_DASH_UNITS = 1'b1;

  // symbol count and dash mask (bit i set = symbol i is a dash)
  typedef struct packed {
    logic [2:0] len;
    logic [3:0] dashes;
  } letter_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [2:0] elem_idx;
  } mck_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       has_elems;
    logic [2:0] last_idx;
  } mck_sts_t;

  function automatic letter_t letter_code(input logic [4:0] idx);
    letter_t l;
    unique case (idx)
      5'd0:    l = '{len: 3'd2, dashes: 4'b0010};
      5'd1:    l = '{len: 3'd4, dashes: 4'b0001};
      5'd2:    l = '{len: 3'd4, dashes: 4'b0101};
      5'd3:    l = '{len: 3'd3, dashes: 4'b0001};
      5'd4:    l = '{len: 3'd1, dashes: 4'b0000};
      5'd5:    l = '{len: 3'd4, dashes: 4'b0100};
      5'd6:    l = '{len: 3'd3, dashes: 4'b0011};
      5'd7:    l = '{len: 3'd4, dashes: 4'b0000};
      5'd8:    l = '{len: 3'd2, dashes: 4'b0000};
      5'd9:    l = '{len: 3'd4, dashes: 4'b1110};
      5'd10:   l = '{len: 3'd3, dashes: 4'b0101};
      5'd11:   l = '{len: 3'd4, dashes: 4'b0010};
      5'd12:   l = '{len: 3'd2, dashes: 4'b0011};
      5'd13:   l = '{len: 3'd2, dashes: 4'b0001};
      5'd14:   l = '{len: 3'd3, dashes: 4'b0111};
      5'd15:   l = '{len: 3'd4, dashes: 4'b0110};
      5'd16:   l = '{len: 3'd4, dashes: 4'b1011};
      5'd17:   l = '{len: 3'd3, dashes: 4'b0010};
      5'd18:   l = '{len: 3'd3, dashes: 4'b0000};
      5'd19:   l = '{len: 3'd1, dashes: 4'b0001};
      5'd20:   l = '{len: 3'd3, dashes: 4'b0100};
      5'd21:   l = '{len: 3'd4, dashes: 4'b1000};
      5'd22:   l = '{len: 3'd3, dashes: 4'b0110};
      5'd23:   l = '{len: 3'd4, dashes: 4'b1001};
      5'd24:   l = '{len: 3'd4, dashes: 4'b1101};
      5'd25:   l = '{len: 3'd4, dashes: 4'b0011};
      default: l = '{len: 3'd0, dashes: 4'b0000};
    endcase
    return l;
  endfunction

endpackage

>>> hdl/mck_datapath.sv
// datapath: config registers, character decode, element timing, output register
// depends on mck_pkg
module mck_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mck_pkg::DotW-1:0]  cfg_wdata,
  input  logic [7:0]                in_char_code,
  input  mck_pkg::mck_cmd_t         cmd,
  output mck_pkg::mck_sts_t         sts,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_line_level,
  output logic [mck_pkg::DurW-1:0]  out_duration_ticks,
  output logic                      out_last_element
);

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SPACE  = 2'd1;
  localparam logic [1:0] KIND_LETTER = 2'd2;

  logic [mck_pkg::DotW-1:0]  dot_ticks_r;
  logic [mck_pkg::DashW-1:0] dash_units_r;
  logic [1:0]                kind_r, kind_nxt;
  mck_pkg::letter_t          letter_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      level_r, level_nxt;
  logic [mck_pkg::DurW-1:0]  dur_r, dur_nxt;
  logic                      last_r, last_nxt;

  logic                      is_upper, is_lower;
  logic [1:0]                sym;
  logic                      on_phase;
  logic [mck_pkg::DurW-1:0]  dot_dur, dash_dur, space_dur;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_ticks_r  <= mck_pkg::DOT_TICKS_RESET;
      dash_units_r <= mck_pkg::DASH_UNITS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mck_pkg::CFG_DOT_TICKS:  dot_ticks_r  <= cfg_wdata;
        mck_pkg::CFG_DASH_UNITS: dash_units_r <= cfg_wdata[mck_pkg::DashW-1:0];
        default:                 dot_ticks_r  <= dot_ticks_r;
      endcase
    end
  end

  // character decode at load
  assign is_upper = (in_char_code >= 8'h41) && (in_char_code <= 8'h5A);
  assign is_lower = (in_char_code >= 8'h61) && (in_char_code <= 8'h7A);

  always_comb begin
    priority if (in_char_code == 8'h20) kind_nxt = KIND_SPACE;
    else if (is_upper || is_lower)      kind_nxt = KIND_LETTER;
    else                                kind_nxt = KIND_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_NONE;
    end else if (cmd.load) begin
      kind_r <= kind_nxt;
    end
  end

  // both cases share the low five bits: 'A' and 'a' map to 1
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      letter_r <= mck_pkg::letter_code(in_char_code[4:0] - 5'd1);
    end
  end

  always_comb begin
    sts.has_elems = (kind_r != KIND_NONE);
    sts.last_idx  = (kind_r == KIND_LETTER) ? {letter_r.len[1:0], 1'b1} - 3'd2 : 3'd0;
    sts.out_free  = !out_valid_r || out_ready;
  end

  // element timing
  assign sym       = cmd.elem_idx[2:1];
  assign on_phase  = !cmd.elem_idx[0];
  assign dot_dur   = mck_pkg::DurW'(dot_ticks_r);
  assign dash_dur  = dot_dur * mck_pkg::DurW'(dash_units_r);
  assign space_dur = dot_dur + {dot_dur[mck_pkg::DurW-2:0], 1'b0};

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    level_nxt     = level_r;
    dur_nxt       = dur_r;
    last_nxt      = last_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (kind_r == KIND_SPACE) begin
        level_nxt = 1'b0;
        dur_nxt   = space_dur;
        last_nxt  = 1'b1;
      end else begin
        level_nxt = on_phase;
        dur_nxt   = (on_phase && letter_r.dashes[sym]) ? dash_dur : dot_dur;
        last_nxt  = !on_phase && ({1'b0, sym} == letter_r.len - 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    dur_r   <= dur_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_line_level     = level_r;
  assign out_duration_ticks = dur_r;
  assign out_last_element   = last_r;

endmodule

>>> hdl/mck_ctrl.sv
// controller: accepts a character and steps through its elements
// depends on mck_pkg and morse_character_keyer_assert.svh
`include "morse_character_keyer_assert.svh"

module mck_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output mck_pkg::mck_cmd_t cmd,
  input  mck_pkg::mck_sts_t sts
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic       state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd.load     = 1'b0;
    cmd.emit     = 1'b0;
    cmd.elem_idx = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = 3'd0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        priority if (!sts.has_elems) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (idx_r == sts.last_idx) begin
            idx_nxt   = 3'd0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // an element goes into the output register only when it has room
  `MCK_ASSERT_IMP(a_emit_room, clk, rst_n, cmd.emit, sts.out_free, "emit with output full")
  // an accepted character blocks the input until the controller is back in idle
  `MCK_ASSERT_NXT(a_busy_after_load, clk, rst_n, in_valid && in_ready, !in_ready,
                  "input open right after accept")
  // the final element ends the character
  `MCK_ASSERT_NXT(a_done_after_last, clk, rst_n, cmd.emit && (idx_r == sts.last_idx),
                  state_r == S_IDLE, "no return to idle after last element")

endmodule

>>> hdl/morse_character_keyer.sv
// a load registers kind_r and letter_r, then each emit registers an output element
// throughput: one element per cycle while out_ready holds; a space gives one element,
// a letter up to eight and an ignored code none
// the controller emits one element a cycle into a single output register when free
// reset: dot_ticks to 250, dash_units to 4, output register empty, input ready
// top level: joins mck_ctrl and mck_datapath, depends on mck_pkg
module morse_character_keyer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mck_pkg::DotW-1:0]  cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_char_code,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_line_level,
  output logic [mck_pkg::DurW-1:0]  out_duration_ticks,
  output logic                      out_last_element
);

  mck_pkg::mck_cmd_t cmd;
  mck_pkg::mck_sts_t sts;

  mck_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mck_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_char_code       (in_char_code),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_line_level     (out_line_level),
    .out_duration_ticks (out_duration_ticks),
    .out_last_element   (out_last_element)
  );

endmodule

>>> tb/morse_character_keyer_tb.sv
// self-checking testbench for morse_character_keyer: characters go in on a valid/ready
// channel, each keying element is predicted in the bench and checked as it comes out
// depends on mck_pkg and the morse_character_keyer rtl
module morse_character_keyer_tb;

  localparam logic [7:0] SPACE_CODE  = 8'h20;
  localparam int         SPACE_UNITS = 3;
  localparam int         SETTLE_CYCLES = 12;

  typedef struct packed {
    logic                     level;
    logic [mck_pkg::DurW-1:0] dur;
    logic                     last;
  } element_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic                        cfg_index;
  logic [mck_pkg::DotW-1:0]    cfg_wdata;
  logic                        in_valid;
  logic                        in_ready;
  logic [7:0]                  in_char_code;
  logic                        out_valid;
  logic                        out_ready;
  logic                        out_line_level;
  logic [mck_pkg::DurW-1:0]    out_duration_ticks;
  logic                        out_last_element;

  // bench copy of the timing registers
  logic [mck_pkg::DotW-1:0]  dot_ticks_q;
  logic [mck_pkg::DashW-1:0] dash_units_q;

  element_t pending_elements[$];
  int       err_count;
  int       send_idle_pct;
  int       recv_stall_pct;

  // dots and dashes for a..z
  string morse_pattern [26] = '{
    ".-",   "-...", "-.-.", "-..",  ".",    "..-.", "--.",  "....",
    "..",   ".---", "-.-",  ".-..", "--",   "-.",   "---",  ".--.",
    "--.-", ".-.",  "...",  "-",    "..-",  "...-", ".--",  "-..-",
    "-.--", "--.."
  };

  morse_character_keyer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_line_level     (out_line_level),
    .out_duration_ticks (out_duration_ticks),
    .out_last_element   (out_last_element)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // expected keying elements for one accepted character
  function automatic void predict_keying(input logic [7:0] code);
    logic [mck_pkg::DurW-1:0] dot_dur;
    logic [mck_pkg::DurW-1:0] dash_dur;
    string                    pat;
    int                       idx;
    dot_dur  = mck_pkg::DurW'(dot_ticks_q);
    dash_dur = mck_pkg::DurW'(dash_units_q) * mck_pkg::DurW'(dot_ticks_q);
    idx      = -1;
    if (code == SPACE_CODE) begin
      pending_elements.push_back('{level: 1'b0, dur: mck_pkg::DurW'(SPACE_UNITS) * dot_dur,
                                   last: 1'b1});
      return;
    end
    if (code >= "A" && code <= "Z") idx = code - "A";
    else if (code >= "a" && code <= "z") idx = code - "a";
    if (idx < 0) return;
    pat = morse_pattern[idx];
    for (int i = 0; i < pat.len(); i++) begin
      pending_elements.push_back('{level: 1'b1,
                                   dur: (pat[i] == "-") ? dash_dur : dot_dur,
                                   last: 1'b0});
      pending_elements.push_back('{level: 1'b0, dur: dot_dur, last: (i == pat.len() - 1)});
    end
  endfunction

  always @(posedge clk) begin
    element_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_elements.size() == 0) begin
        if (err_count < 10)
          $display("unexpected element: level %0b dur %0d last %0b",
                   out_line_level, out_duration_ticks, out_last_element);
        err_count++;
      end else begin
        want = pending_elements.pop_front();
        if (out_line_level !== want.level || out_duration_ticks !== want.dur ||
            out_last_element !== want.last) begin
          if (err_count < 10)
            $display("element mismatch: exp level %0b dur %0d last %0b, got %0b %0d %0b",
                     want.level, want.dur, want.last,
                     out_line_level, out_duration_ticks, out_last_element);
          err_count++;
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_keying(code);
  endtask

  // wait for every expected element, then let an ignored code finish too
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_elements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while idle; upper write bits of dash_units are junk on purpose
  task automatic set_timing(input logic [mck_pkg::DotW-1:0] dot_val,
                            input logic [mck_pkg::DotW-1:0] dash_raw);
    cfg_we    <= 1'b1;
    cfg_index <= mck_pkg::CFG_DOT_TICKS;
    cfg_wdata <= dot_val;
    @(posedge clk);
    cfg_index <= mck_pkg::CFG_DASH_UNITS;
    cfg_wdata <= dash_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    dot_ticks_q  = dot_val;
    dash_units_q = dash_raw[mck_pkg::DashW-1:0];
  endtask

  function automatic logic [7:0] random_char;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 8'("A" + $urandom_range(25)) | {2'b00, 1'($urandom), 5'b0};
    if (pick < 82) return SPACE_CODE;
    return 8'($urandom);
  endfunction

  task automatic test_default_timing;
    send_char("E");
    send_char("T");
    send_char(SPACE_CODE);
    send_char("q");
    drain();
  endtask

  task automatic test_character_set;
    logic [7:0] codes [$];
    codes = '{8'h00, 8'hFF, "A", "Z", "a", "z", 8'h40, 8'h5B, 8'h60, 8'h7B,
              SPACE_CODE, 8'h1F, 8'h21, "X", "Y", "x", "y", "J", "0", 8'h80, 8'hC1};
    foreach (codes[i]) send_char(codes[i]);
    drain();
  endtask

  task automatic test_timing_extremes;
    set_timing(16'hFFFF, 16'hFFFF);
    send_char("O");
    send_char("j");
    send_char(SPACE_CODE);
    drain();
    set_timing(16'h0000, 16'hFFF0);
    send_char("Q");
    send_char(SPACE_CODE);
    send_char("k");
    drain();
    set_timing(16'h0001, 16'h0001);
    send_char("B");
    send_char(SPACE_CODE);
    drain();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    set_timing(16'($urandom), 16'($urandom));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_char(random_char());
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    err_count      = 0;
    dot_ticks_q    = mck_pkg::DOT_TICKS_RESET;
    dash_units_q   = mck_pkg::DASH_UNITS_RESET;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= mck_pkg::CFG_DOT_TICKS;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_char_code <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_timing();
    test_character_set();
    test_timing_extremes();
    test_random_traffic(0, 0, 105);
    test_random_traffic(79, 0, 105);
    test_random_traffic(0, 79, 105);
    test_random_traffic(24, 24, 105);

    if (err_count == 0) begin
      $display("morse_character_keyer regression: pass");
    end else begin
      $display("morse_character_keyer regression: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("morse_character_keyer regression: fail");
    $finish;
  end

endmodule
